FILE: rtl/core/pwb_pkg.sv
// ----------------------------------------------------------------------------
// pwb_pkg: shared types and constants of the perspective warp core
// Holds the coefficient register codes, their reset values and the request
// record that travels from the front end to the back end.
// ----------------------------------------------------------------------------
package pwb_pkg;

    // Fixed field widths of the request and result records.
    localparam int NUM_REGS    = 8;
    localparam int COEF_BITS   = 32;
    localparam int POS_BITS    = 12;
    localparam int SAMP_MAX    = 16;
    localparam int NUM_CH      = 3;
    localparam int REG_IDX_BITS = 3;

    // Projection arithmetic widths.
    localparam int PROD_BITS   = 45;
    localparam int SUM_BITS    = 46;
    localparam int DEN_BITS    = 45;
    localparam int PRE_SHIFT   = 14;
    localparam int W_ONE_SHIFT = 30;

    // Input request queue.
    localparam int QUEUE_DEPTH = 4;

    // Coefficient register indexes.
    localparam logic [REG_IDX_BITS-1:0] REG_U_X = 3'd0;
    localparam logic [REG_IDX_BITS-1:0] REG_U_Y = 3'd1;
    localparam logic [REG_IDX_BITS-1:0] REG_U_C = 3'd2;
    localparam logic [REG_IDX_BITS-1:0] REG_V_X = 3'd3;
    localparam logic [REG_IDX_BITS-1:0] REG_V_Y = 3'd4;
    localparam logic [REG_IDX_BITS-1:0] REG_V_C = 3'd5;
    localparam logic [REG_IDX_BITS-1:0] REG_W_X = 3'd6;
    localparam logic [REG_IDX_BITS-1:0] REG_W_Y = 3'd7;

    // Request opcodes.
    localparam logic OP_WRITE   = 1'b0;
    localparam logic OP_PROJECT = 1'b1;

    typedef logic [COEF_BITS-1:0] coef_t;
    typedef coef_t [NUM_REGS-1:0] coef_bank_t;

    // Reset values: identity mapping, unit scale on u and v.
    localparam coef_bank_t COEF_RESET = {
        32'd0, 32'd0, 32'd0, 32'd65536, 32'd0, 32'd0, 32'd0, 32'd65536
    };

    // One queued request.
    typedef struct packed {
        logic                                is_write;
        logic [POS_BITS-1:0]                 x;
        logic [POS_BITS-1:0]                 y;
        logic [NUM_CH-1:0][SAMP_MAX-1:0]     samp;
    } item_t;

endpackage

FILE: rtl/core/pwb_front.sv
// ----------------------------------------------------------------------------
// pwb_front: request intake and classification
// Accepts requests, drops writes that fall outside the source image and
// queues the rest in order for the back end.
// ----------------------------------------------------------------------------
module pwb_front #(
    parameter int SRC_WIDTH  = 256,
    parameter int SRC_HEIGHT = 256
) (
    input  logic                                                clk,
    input  logic                                                rst_n,
    input  logic                                                in_valid,
    output logic                                                in_ready,
    input  logic                                                opcode,
    input  logic [pwb_pkg::POS_BITS-1:0]                        pos_x,
    input  logic [pwb_pkg::POS_BITS-1:0]                        pos_y,
    input  logic [pwb_pkg::NUM_CH-1:0][pwb_pkg::SAMP_MAX-1:0]   samp_in,
    output logic                                                q_valid,
    output pwb_pkg::item_t                                      q_item,
    input  logic                                                q_pop
);

    localparam int DEPTH = pwb_pkg::QUEUE_DEPTH;
    localparam int PW    = $clog2(DEPTH);
    localparam int CW    = pwb_pkg::POS_BITS + 1;

    logic [PW-1:0]  wr_ptr_reg;
    logic [PW-1:0]  rd_ptr_reg;
    logic [PW:0]    count_reg;
    logic [PW:0]    count_next;
    pwb_pkg::item_t slot_reg [DEPTH];
    pwb_pkg::item_t item;
    logic           accept;
    logic           outside;
    logic           push;

    // Classify the request: a write outside the image has no effect.
    assign outside = (CW'(pos_x) >= CW'(SRC_WIDTH)) || (CW'(pos_y) >= CW'(SRC_HEIGHT));
    assign accept  = in_valid && in_ready;
    assign push    = accept && !((opcode == pwb_pkg::OP_WRITE) && outside);
    assign in_ready = (count_reg != (PW+1)'(DEPTH));

    always_comb
    begin
        item.is_write = (opcode == pwb_pkg::OP_WRITE);
        item.x        = pos_x;
        item.y        = pos_y;
        item.samp     = samp_in;
    end

    // Queue occupancy and pointers.
    always_comb
    begin
        count_next = count_reg;
        if (push && !q_pop)
        begin
            count_next = count_reg + (PW+1)'(1);
        end
        else if (!push && q_pop)
        begin
            count_next = count_reg - (PW+1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PW'(1);
            end
            if (q_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PW'(1);
            end
        end
    end

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= item;
        end
    end

    assign q_valid = (count_reg != '0);
    assign q_item  = slot_reg[rd_ptr_reg];

endmodule

FILE: rtl/core/pwb_div.sv
// ----------------------------------------------------------------------------
// pwb_div: pipelined restoring divider for one source coordinate
// Computes floor(num * 2^(14+F) / den) one quotient bit per stage and flags
// a negative numerator or a quotient that does not fit.
// ----------------------------------------------------------------------------
module pwb_div #(
    parameter int QBITS = 16,
    parameter int SHIFT = 6
) (
    input  logic                                  clk,
    input  logic                                  en,
    input  logic signed [pwb_pkg::SUM_BITS-1:0]   num,
    input  logic [pwb_pkg::DEN_BITS-1:0]          den,
    output logic [QBITS-1:0]                      quot,
    output logic                                  neg,
    output logic                                  sat
);

    localparam int NB = pwb_pkg::DEN_BITS;
    localparam int RB = NB + SHIFT;

    logic [NB-1:0]    rem_reg  [QBITS+1];
    logic [NB-1:0]    den_reg  [QBITS+1];
    logic [QBITS-1:0] quot_reg [QBITS+1];
    logic             neg_reg  [QBITS+1];
    logic             sat_reg  [QBITS+1];
    logic [RB-1:0]    top_part;

    // The dividend's upper part; if it already reaches den the quotient overflows.
    assign top_part = {num[NB-1:0], SHIFT'(0)};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]  <= top_part[NB-1:0];
            den_reg[0]  <= den;
            quot_reg[0] <= '0;
            neg_reg[0]  <= num[pwb_pkg::SUM_BITS-1];
            sat_reg[0]  <= (top_part >= RB'(den));
        end
    end

    // One quotient bit per stage; the dividend's low bits are all zero.
    for (genvar i = 0; i < QBITS; i++)
    begin : g_step
        logic [NB:0] trial;
        logic [NB:0] diff;
        logic        ge;

        assign trial = {rem_reg[i], 1'b0};
        assign diff  = trial - {1'b0, den_reg[i]};
        assign ge    = (trial >= {1'b0, den_reg[i]});

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i+1]  <= ge ? diff[NB-1:0] : trial[NB-1:0];
                den_reg[i+1]  <= den_reg[i];
                quot_reg[i+1] <= {quot_reg[i][QBITS-2:0], ge};
                neg_reg[i+1]  <= neg_reg[i];
                sat_reg[i+1]  <= sat_reg[i];
            end
        end
    end

    assign quot = quot_reg[QBITS];
    assign neg  = neg_reg[QBITS];
    assign sat  = sat_reg[QBITS];

endmodule

FILE: rtl/core/pwb_back.sv
// ----------------------------------------------------------------------------
// pwb_back: projection, source store and bilinear interpolation
// Takes queued requests in order: writes update the banked source store,
// projections are mapped, divided, clamped, read and interpolated.
// ----------------------------------------------------------------------------
module pwb_back #(
    parameter int SRC_WIDTH   = 256,
    parameter int SRC_HEIGHT  = 256,
    parameter int CHANNELS    = 3,
    parameter int SAMPLE_BITS = 16,
    parameter int FRAC_BITS   = 8
) (
    input  logic                                                clk,
    input  logic                                                rst_n,
    input  pwb_pkg::coef_bank_t                                 coef,
    input  logic                                                q_valid,
    input  pwb_pkg::item_t                                      q_item,
    output logic                                                q_pop,
    output logic                                                out_valid,
    input  logic                                                out_ready,
    output logic [pwb_pkg::POS_BITS-1:0]                        dest_x,
    output logic [pwb_pkg::POS_BITS-1:0]                        dest_y,
    output logic [pwb_pkg::NUM_CH-1:0][pwb_pkg::SAMP_MAX-1:0]   samp_out,
    output logic                                                valid_res
);

    localparam int XW     = $clog2(SRC_WIDTH);
    localparam int YW     = $clog2(SRC_HEIGHT);
    localparam int MAXDIM = (SRC_WIDTH > SRC_HEIGHT) ? SRC_WIDTH : SRC_HEIGHT;
    localparam int QB     = $clog2(MAXDIM) + FRAC_BITS;
    localparam int SH     = pwb_pkg::PRE_SHIFT + FRAC_BITS - QB;
    localparam int SB     = SAMPLE_BITS;
    localparam int MW     = CHANNELS * SB;
    localparam int HALF_W = (SRC_WIDTH + 1) / 2;
    localparam int HALF_H = (SRC_HEIGHT + 1) / 2;
    localparam int BANK_DEPTH = HALF_W * HALF_H;
    localparam int AW     = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
    localparam int WB     = 2 * FRAC_BITS + 1;
    localparam int PB     = SB + WB;
    localparam int AB     = PB + 2;
    localparam int PBITS  = pwb_pkg::POS_BITS;
    localparam int SUMB   = pwb_pkg::SUM_BITS;
    localparam int PRODB  = pwb_pkg::PROD_BITS;

    localparam logic [QB-1:0]        LIM_QX = QB'(SRC_WIDTH - 1) << FRAC_BITS;
    localparam logic [QB-1:0]        LIM_QY = QB'(SRC_HEIGHT - 1) << FRAC_BITS;
    localparam logic [FRAC_BITS:0]   ONE    = (FRAC_BITS+1)'(1) << FRAC_BITS;
    localparam logic [AB-1:0]        RND    = AB'(1) << (2 * FRAC_BITS - 1);
    localparam logic signed [SUMB-1:0] W_ONE = SUMB'(1) << pwb_pkg::W_ONE_SHIFT;

    typedef struct packed {
        logic                                               is_write;
        logic                                               w_pos;
        logic [PBITS-1:0]                                   x;
        logic [PBITS-1:0]                                   y;
        logic [pwb_pkg::NUM_CH-1:0][pwb_pkg::SAMP_MAX-1:0]  samp;
    } side_t;

    // Source store address of a pixel inside its parity bank.
    function automatic logic [AW-1:0] bank_addr(input logic [XW-1:0] col,
                                                input logic [YW-1:0] row);
        logic [31:0] lin;
        lin = (32'(row) >> 1) * 32'(HALF_W) + (32'(col) >> 1);
        return lin[AW-1:0];
    endfunction

    function automatic logic [MW-1:0] pick(input logic [1:0] sel,
                                           input logic [MW-1:0] b0,
                                           input logic [MW-1:0] b1,
                                           input logic [MW-1:0] b2,
                                           input logic [MW-1:0] b3);
        logic [MW-1:0] r;
        case (sel)
            2'd0:    r = b0;
            2'd1:    r = b1;
            2'd2:    r = b2;
            default: r = b3;
        endcase
        return r;
    endfunction

    logic en;
    logic outv_reg;

    // The whole back end moves when the result register can take a result.
    assign en    = !outv_reg || out_ready;
    assign q_pop = en && q_valid;

    // ------------------------------------------------------------------
    // Stage 1: coefficient products.
    // ------------------------------------------------------------------
    logic                     v1_reg;
    side_t                    s1_reg;
    logic signed [PRODB-1:0]  ux_reg, uy_reg, vx_reg, vy_reg, wx_reg, wy_reg;
    logic signed [PBITS:0]    xs;
    logic signed [PBITS:0]    ys;

    assign xs = $signed({1'b0, q_item.x});
    assign ys = $signed({1'b0, q_item.y});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= q_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_reg.is_write <= q_item.is_write;
            s1_reg.w_pos    <= 1'b0;
            s1_reg.x        <= q_item.x;
            s1_reg.y        <= q_item.y;
            s1_reg.samp     <= q_item.samp;
            ux_reg <= $signed(coef[pwb_pkg::REG_U_X]) * xs;
            uy_reg <= $signed(coef[pwb_pkg::REG_U_Y]) * ys;
            vx_reg <= $signed(coef[pwb_pkg::REG_V_X]) * xs;
            vy_reg <= $signed(coef[pwb_pkg::REG_V_Y]) * ys;
            wx_reg <= $signed(coef[pwb_pkg::REG_W_X]) * xs;
            wy_reg <= $signed(coef[pwb_pkg::REG_W_Y]) * ys;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: numerators and denominator.
    // ------------------------------------------------------------------
    logic                    v2_reg;
    side_t                   s2_reg;
    logic signed [SUMB-1:0]  u_reg, v_reg, w_reg;
    logic                    w_pos;
    side_t                   s2_tag;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_reg <= s1_reg;
            u_reg  <= SUMB'(ux_reg) + SUMB'(uy_reg)
                    + SUMB'($signed(coef[pwb_pkg::REG_U_C]));
            v_reg  <= SUMB'(vx_reg) + SUMB'(vy_reg)
                    + SUMB'($signed(coef[pwb_pkg::REG_V_C]));
            w_reg  <= SUMB'(wx_reg) + SUMB'(wy_reg) + W_ONE;
        end
    end

    assign w_pos = !w_reg[SUMB-1] && (w_reg != '0);

    // The request record tagged with the sign of its denominator.
    always_comb
    begin
        s2_tag       = s2_reg;
        s2_tag.w_pos = w_pos;
    end

    // ------------------------------------------------------------------
    // Division stages, with the request record delayed alongside.
    // ------------------------------------------------------------------
    logic [QB-1:0] quot_x, quot_y;
    logic          neg_x, neg_y, sat_x, sat_y;
    logic          dv_reg [QB+1];
    side_t         ds_reg [QB+1];

    pwb_div #(
        .QBITS (QB),
        .SHIFT (SH)
    ) u_div_x (
        .clk  (clk),
        .en   (en),
        .num  (u_reg),
        .den  (w_reg[pwb_pkg::DEN_BITS-1:0]),
        .quot (quot_x),
        .neg  (neg_x),
        .sat  (sat_x)
    );

    pwb_div #(
        .QBITS (QB),
        .SHIFT (SH)
    ) u_div_y (
        .clk  (clk),
        .en   (en),
        .num  (v_reg),
        .den  (w_reg[pwb_pkg::DEN_BITS-1:0]),
        .quot (quot_y),
        .neg  (neg_y),
        .sat  (sat_y)
    );

    for (genvar i = 0; i <= QB; i++)
    begin : g_delay
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_reg[i] <= 1'b0;
            end
            else if (en)
            begin
                dv_reg[i] <= (i == 0) ? v2_reg : dv_reg[(i == 0) ? 0 : i-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (i == 0)
                begin
                    ds_reg[i] <= s2_tag;
                end
                else
                begin
                    ds_reg[i] <= ds_reg[(i == 0) ? 0 : i-1];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage C: clamp to the image and split integer and fraction.
    // ------------------------------------------------------------------
    logic                 vc_reg;
    side_t                sc_reg;
    logic [XW-1:0]        xl_reg, xh_reg;
    logic [YW-1:0]        yl_reg, yh_reg;
    logic [FRAC_BITS-1:0] dx_reg, dy_reg;
    logic [QB-1:0]        qx, qy;
    logic [XW-1:0]        xl;
    logic [YW-1:0]        yl;
    logic [XW:0]          xl_inc;
    logic [YW:0]          yl_inc;

    always_comb
    begin
        if (neg_x)
        begin
            qx = '0;
        end
        else if (sat_x || (quot_x >= LIM_QX))
        begin
            qx = LIM_QX;
        end
        else
        begin
            qx = quot_x;
        end
        if (neg_y)
        begin
            qy = '0;
        end
        else if (sat_y || (quot_y >= LIM_QY))
        begin
            qy = LIM_QY;
        end
        else
        begin
            qy = quot_y;
        end
    end

    assign xl     = qx[FRAC_BITS +: XW];
    assign yl     = qy[FRAC_BITS +: YW];
    assign xl_inc = {1'b0, xl} + (XW+1)'(1);
    assign yl_inc = {1'b0, yl} + (YW+1)'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vc_reg <= 1'b0;
        end
        else if (en)
        begin
            vc_reg <= dv_reg[QB];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sc_reg <= ds_reg[QB];
            xl_reg <= xl;
            yl_reg <= yl;
            xh_reg <= (xl_inc < (XW+1)'(SRC_WIDTH)) ? xl_inc[XW-1:0] : xl;
            yh_reg <= (yl_inc < (YW+1)'(SRC_HEIGHT)) ? yl_inc[YW-1:0] : yl;
            dx_reg <= qx[FRAC_BITS-1:0];
            dy_reg <= qy[FRAC_BITS-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Stage A: bank addresses, write address and bilinear weights.
    // Bank index is {row parity, column parity}.
    // ------------------------------------------------------------------
    logic                 va_reg;
    side_t                sa_reg;
    logic                 wr_a_reg;
    logic [1:0]           wbank_a_reg;
    logic [AW-1:0]        waddr_a_reg;
    logic [MW-1:0]        wdata_a_reg;
    logic [AW-1:0]        raddr_a_reg [4];
    logic [1:0]           sel_a_reg   [4];
    logic [WB-1:0]        wt_a_reg    [4];
    logic [FRAC_BITS:0]   ndx, ndy, pdx, pdy;
    logic [MW-1:0]        wdata;

    assign ndx = ONE - (FRAC_BITS+1)'(dx_reg);
    assign ndy = ONE - (FRAC_BITS+1)'(dy_reg);
    assign pdx = (FRAC_BITS+1)'(dx_reg);
    assign pdy = (FRAC_BITS+1)'(dy_reg);

    for (genvar c = 0; c < CHANNELS; c++)
    begin : g_wdata
        assign wdata[c*SB +: SB] = sc_reg.samp[c][SB-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
        end
        else if (en)
        begin
            va_reg <= vc_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sa_reg      <= sc_reg;
            wr_a_reg    <= vc_reg && sc_reg.is_write;
            wbank_a_reg <= {sc_reg.y[0], sc_reg.x[0]};
            waddr_a_reg <= bank_addr(sc_reg.x[XW-1:0], sc_reg.y[YW-1:0]);
            wdata_a_reg <= wdata;
            sel_a_reg[0] <= {yl_reg[0], xl_reg[0]};
            sel_a_reg[1] <= {yl_reg[0], xh_reg[0]};
            sel_a_reg[2] <= {yh_reg[0], xl_reg[0]};
            sel_a_reg[3] <= {yh_reg[0], xh_reg[0]};
            wt_a_reg[0] <= WB'(ndx * ndy);
            wt_a_reg[1] <= WB'(pdx * ndy);
            wt_a_reg[2] <= WB'(ndx * pdy);
            wt_a_reg[3] <= WB'(pdx * pdy);
        end
    end

    for (genvar b = 0; b < 4; b++)
    begin : g_raddr
        localparam logic PX = 1'(b % 2);
        localparam logic PY = 1'(b / 2);
        logic [XW-1:0] col;
        logic [YW-1:0] row;

        assign col = (xl_reg[0] == PX) ? xl_reg : xh_reg;
        assign row = (yl_reg[0] == PY) ? yl_reg : yh_reg;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                raddr_a_reg[b] <= bank_addr(col, row);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage M: four parity banks, one write and one read each.
    // ------------------------------------------------------------------
    logic          vm_reg;
    side_t         sm_reg;
    logic [1:0]    sel_m_reg [4];
    logic [WB-1:0] wt_m_reg  [4];
    logic [MW-1:0] rd_reg    [4];

    for (genvar b = 0; b < 4; b++)
    begin : g_bank
        logic [MW-1:0] mem [BANK_DEPTH];

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (wr_a_reg && (wbank_a_reg == 2'(b)))
                begin
                    mem[waddr_a_reg] <= wdata_a_reg;
                end
                rd_reg[b] <= mem[raddr_a_reg[b]];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vm_reg <= 1'b0;
        end
        else if (en)
        begin
            vm_reg <= va_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sm_reg    <= sa_reg;
            sel_m_reg <= sel_a_reg;
            wt_m_reg  <= wt_a_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage P: route the neighbours and weight every sample.
    // ------------------------------------------------------------------
    logic          vp_reg;
    side_t         sp_reg;
    logic [MW-1:0] pix [4];
    logic [PB-1:0] prod_reg [CHANNELS][4];

    for (genvar k = 0; k < 4; k++)
    begin : g_pick
        assign pix[k] = pick(sel_m_reg[k], rd_reg[0], rd_reg[1], rd_reg[2], rd_reg[3]);
    end

    for (genvar c = 0; c < CHANNELS; c++)
    begin : g_mul
        for (genvar k = 0; k < 4; k++)
        begin : g_tap
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    prod_reg[c][k] <= PB'(pix[k][c*SB +: SB]) * PB'(wt_m_reg[k]);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vp_reg <= 1'b0;
        end
        else if (en)
        begin
            vp_reg <= vm_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sp_reg <= sm_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage S: sum, round half up and register the result.
    // ------------------------------------------------------------------
    logic [pwb_pkg::NUM_CH-1:0][pwb_pkg::SAMP_MAX-1:0] chan_val;
    logic [pwb_pkg::NUM_CH-1:0][pwb_pkg::SAMP_MAX-1:0] samp_reg;
    logic [PBITS-1:0] dest_x_reg, dest_y_reg;
    logic             valid_res_reg;

    for (genvar c = 0; c < pwb_pkg::NUM_CH; c++)
    begin : g_sum
        if (c < CHANNELS)
        begin : g_used
            logic [AB-1:0] acc;
            assign acc = AB'(prod_reg[c][0]) + AB'(prod_reg[c][1])
                       + AB'(prod_reg[c][2]) + AB'(prod_reg[c][3]) + RND;
            assign chan_val[c] = pwb_pkg::SAMP_MAX'(acc[2*FRAC_BITS +: SB]);
        end
        else
        begin : g_unused
            assign chan_val[c] = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            outv_reg <= 1'b0;
        end
        else if (en)
        begin
            outv_reg <= vp_reg && !sp_reg.is_write;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dest_x_reg    <= sp_reg.x;
            dest_y_reg    <= sp_reg.y;
            valid_res_reg <= sp_reg.w_pos;
            samp_reg      <= sp_reg.w_pos ? chan_val : '0;
        end
    end

    assign out_valid = outv_reg;
    assign dest_x    = dest_x_reg;
    assign dest_y    = dest_y_reg;
    assign samp_out  = samp_reg;
    assign valid_res = valid_res_reg;

endmodule

FILE: rtl/core/perspective_warp_bilinear_core.sv
// ----------------------------------------------------------------------------
// perspective_warp_bilinear_core: homography warp with bilinear sampling
// Top level: coefficient registers, request front end and processing back end.
// ----------------------------------------------------------------------------
// The core accepts one request per clock while its queue has room and returns
// one result per clock for projection requests while out_ready is high; write
// requests load the source store and return nothing. The restoring dividers
// resolve one quotient bit per pipeline stage for a QB-bit quotient, where
// QB = clog2(max(SRC_WIDTH, SRC_HEIGHT)) + FRAC_BITS (16 at the defaults). The
// source store is split into four banks by row and column parity, each with
// one write and one read per clock, so the four pixels of a 2x2 neighbourhood
// are read in the same cycle. There is no clearing pass after reset: read only
// pixels that have been written. A four-entry request queue decouples intake
// from the back end, so a stalled result only holds the input once the queue
// is full. Load the coefficients while no request is in flight.
module perspective_warp_bilinear_core #(
    parameter int SRC_WIDTH   = 256,
    parameter int SRC_HEIGHT  = 256,
    parameter int CHANNELS    = 3,
    parameter int SAMPLE_BITS = 16,
    parameter int FRAC_BITS   = 8
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic                                   opcode,
    input  logic [pwb_pkg::POS_BITS-1:0]           pos_x,
    input  logic [pwb_pkg::POS_BITS-1:0]           pos_y,
    input  logic [pwb_pkg::SAMP_MAX-1:0]           sample_in_0,
    input  logic [pwb_pkg::SAMP_MAX-1:0]           sample_in_1,
    input  logic [pwb_pkg::SAMP_MAX-1:0]           sample_in_2,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic [pwb_pkg::POS_BITS-1:0]           dest_x,
    output logic [pwb_pkg::POS_BITS-1:0]           dest_y,
    output logic [pwb_pkg::SAMP_MAX-1:0]           sample_out_0,
    output logic [pwb_pkg::SAMP_MAX-1:0]           sample_out_1,
    output logic [pwb_pkg::SAMP_MAX-1:0]           sample_out_2,
    output logic                                   valid_res,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [pwb_pkg::REG_IDX_BITS-1:0]       cfg_index,
    input  logic [pwb_pkg::COEF_BITS-1:0]          cfg_data
);

    pwb_pkg::coef_bank_t                                coef_reg;
    logic [pwb_pkg::NUM_CH-1:0][pwb_pkg::SAMP_MAX-1:0]  samp_in;
    logic [pwb_pkg::NUM_CH-1:0][pwb_pkg::SAMP_MAX-1:0]  samp_out;
    logic                                               q_valid;
    logic                                               q_pop;
    pwb_pkg::item_t                                     q_item;

    // Coefficient registers; writes are always taken.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg <= pwb_pkg::COEF_RESET;
        end
        else if (cfg_valid)
        begin
            coef_reg[cfg_index] <= cfg_data;
        end
    end

    assign samp_in = {sample_in_2, sample_in_1, sample_in_0};

    pwb_front #(
        .SRC_WIDTH  (SRC_WIDTH),
        .SRC_HEIGHT (SRC_HEIGHT)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .opcode   (opcode),
        .pos_x    (pos_x),
        .pos_y    (pos_y),
        .samp_in  (samp_in),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop)
    );

    pwb_back #(
        .SRC_WIDTH   (SRC_WIDTH),
        .SRC_HEIGHT  (SRC_HEIGHT),
        .CHANNELS    (CHANNELS),
        .SAMPLE_BITS (SAMPLE_BITS),
        .FRAC_BITS   (FRAC_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .coef      (coef_reg),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .dest_x    (dest_x),
        .dest_y    (dest_y),
        .samp_out  (samp_out),
        .valid_res (valid_res)
    );

    assign sample_out_0 = samp_out[0];
    assign sample_out_1 = samp_out[1];
    assign sample_out_2 = samp_out[2];

    // The back end never takes a request from an empty queue.
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid)
        else $error("request taken from an empty queue");

    // A result with a non-positive denominator carries zero samples.
    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !valid_res) |->
        (sample_out_0 == '0 && sample_out_1 == '0 && sample_out_2 == '0))
        else $error("invalid result carries nonzero samples");

    // A channel beyond the configured count always reads zero; this checks the third one.
    a_unused_channel: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (CHANNELS < 3)) |-> (sample_out_2 == '0))
        else $error("unused channel carries a nonzero sample");

endmodule
